// File: rtl/hsvws_pkg.sv
// Shared types and constants for the HSV to WS2812 pulse encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsvws_pkg;

  localparam int unsigned LedCount   = 64;   // strip length, 1..256
  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned SectorDeg  = 60;
  localparam int unsigned HueLimit   = 360;

  localparam int unsigned DutyW  = 6;
  localparam int unsigned SlotW  = 14;
  localparam int unsigned CntW   = 5;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned ApbAddrW = 3;

  // floor(m/60) as (m * Recip60) >> Recip60Sh, exact for m <= 255*60
  localparam int unsigned Recip60   = 17477;
  localparam int unsigned Recip60Sh = 20;

  localparam logic [DutyW-1:0] DutyOneRst  = DutyW'(40);
  localparam logic [DutyW-1:0] DutyZeroRst = DutyW'(20);

  localparam logic [ApbAddrW-1:0] AddrDutyOne  = ApbAddrW'(0);
  localparam logic [ApbAddrW-1:0] AddrDutyZero = ApbAddrW'(4);

  typedef enum logic [2:0] {
    SecRedGreen   = 3'd0,
    SecGreenRed   = 3'd1,
    SecGreenBlue  = 3'd2,
    SecBlueGreen  = 3'd3,
    SecBlueRed    = 3'd4,
    SecRedBlue    = 3'd5,
    SecBlack      = 3'd6
  } sector_e;

  typedef struct packed {
    logic [DutyW-1:0] duty_one;
    logic [DutyW-1:0] duty_zero;
  } duty_cfg_t;

  // colour item handed from the colour pipeline to the serializer
  typedef struct packed {
    logic             err;
    logic [SlotW-1:0] base;
    logic [23:0]      grb;
  } pix_item_t;

endpackage

`default_nettype wire

// File: rtl/hsvws_cfg_regs.sv
// APB register file for the two duty codes.
// Depends on hsvws_pkg.
`default_nettype none

module hsvws_cfg_regs
  import hsvws_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel_i,
  input  wire logic                penable_i,
  input  wire logic                pwrite_i,
  input  wire logic [ApbAddrW-1:0] paddr_i,
  input  wire logic [31:0]         pwdata_i,
  output logic      [31:0]         prdata_o,
  output logic                     pready_o,
  output duty_cfg_t                cfg_o
);

  logic [DutyW-1:0] duty_one_q, duty_one_d;
  logic [DutyW-1:0] duty_zero_q, duty_zero_d;
  logic             wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;

  // decode on the word address bit
  always_comb begin
    duty_one_d  = duty_one_q;
    duty_zero_d = duty_zero_q;
    if (wr_en) begin
      if (paddr_i[2] == AddrDutyZero[2]) begin
        duty_zero_d = pwdata_i[DutyW-1:0];
      end else begin
        duty_one_d = pwdata_i[DutyW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_one_q  <= DutyOneRst;
      duty_zero_q <= DutyZeroRst;
    end else begin
      duty_one_q  <= duty_one_d;
      duty_zero_q <= duty_zero_d;
    end
  end

  always_comb begin
    if (paddr_i[2] == AddrDutyOne[2]) begin
      prdata_o = {{(32-DutyW){1'b0}}, duty_one_q};
    end else begin
      prdata_o = {{(32-DutyW){1'b0}}, duty_zero_q};
    end
  end

  assign cfg_o.duty_one  = duty_one_q;
  assign cfg_o.duty_zero = duty_zero_q;

endmodule

`default_nettype wire

// File: rtl/hsvws_color_pipe.sv
// Four-stage HSV to GRB pipeline: product, chroma, slope product, slope divide.
// Depends on hsvws_pkg.
`default_nettype none

module hsvws_color_pipe
  import hsvws_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic [7:0] led_i,
  input  wire logic [8:0] hue_i,
  input  wire logic [7:0] sat_i,
  input  wire logic [7:0] val_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output pix_item_t  out_item_o
);

  // stage A: sector decode, s*v
  logic             a_vld_q;
  logic             a_err_q;
  logic [SlotW-1:0] a_base_q;
  sector_e          a_sec_q, a_sec_d;
  logic [5:0]       a_off_q, a_off_d;
  logic [7:0]       a_v_q;
  logic [15:0]      a_p_q;
  // stage B: chroma and min
  logic             b_vld_q;
  logic             b_err_q;
  logic [SlotW-1:0] b_base_q;
  sector_e          b_sec_q;
  logic [5:0]       b_off_q;
  logic [7:0]       b_v_q, b_chroma_q, b_lo_q;
  // stage C: chroma*offset
  logic             c_vld_q;
  logic             c_err_q;
  logic [SlotW-1:0] c_base_q;
  sector_e          c_sec_q;
  logic [7:0]       c_v_q, c_lo_q;
  logic [13:0]      c_m_q;
  // stage D: packed colour
  logic             d_vld_q;
  pix_item_t        d_item_q, d_item_d;

  logic a_en, b_en, c_en, d_en;
  logic [16:0] b_t;
  logic [28:0] d_prod;
  logic [7:0]  d_slope;

  assign d_en = ~d_vld_q | out_ready_i;
  assign c_en = ~c_vld_q | d_en;
  assign b_en = ~b_vld_q | c_en;
  assign a_en = ~a_vld_q | b_en;
  assign in_ready_o = a_en;

  always_comb begin
    a_sec_d = SecBlack;
    a_off_d = '0;
    if (hue_i < 9'(SectorDeg)) begin
      a_sec_d = SecRedGreen;
      a_off_d = hue_i[5:0];
    end else if (hue_i < 9'(2*SectorDeg)) begin
      a_sec_d = SecGreenRed;
      a_off_d = 6'(9'(2*SectorDeg) - hue_i);
    end else if (hue_i < 9'(3*SectorDeg)) begin
      a_sec_d = SecGreenBlue;
      a_off_d = 6'(hue_i - 9'(2*SectorDeg));
    end else if (hue_i < 9'(4*SectorDeg)) begin
      a_sec_d = SecBlueGreen;
      a_off_d = 6'(9'(4*SectorDeg) - hue_i);
    end else if (hue_i < 9'(5*SectorDeg)) begin
      a_sec_d = SecBlueRed;
      a_off_d = 6'(hue_i - 9'(4*SectorDeg));
    end else if (hue_i < 9'(HueLimit)) begin
      a_sec_d = SecRedBlue;
      a_off_d = 6'(9'(HueLimit) - hue_i);
    end
  end

  // p/255 = (p + (p >> 8) + 1) >> 8 over the product range
  assign b_t = 17'(a_p_q) + 17'(a_p_q[15:8]) + 17'd1;

  assign d_prod  = 29'(c_m_q) * 29'(Recip60);
  assign d_slope = c_lo_q + d_prod[Recip60Sh +: 8];

  always_comb begin
    d_item_d.err  = c_err_q;
    d_item_d.base = c_base_q;
    case (c_sec_q)
      SecRedGreen:  d_item_d.grb = {d_slope, c_v_q, c_lo_q};
      SecGreenRed:  d_item_d.grb = {c_v_q, d_slope, c_lo_q};
      SecGreenBlue: d_item_d.grb = {c_v_q, c_lo_q, d_slope};
      SecBlueGreen: d_item_d.grb = {d_slope, c_lo_q, c_v_q};
      SecBlueRed:   d_item_d.grb = {c_lo_q, d_slope, c_v_q};
      SecRedBlue:   d_item_d.grb = {c_lo_q, c_v_q, d_slope};
      default:      d_item_d.grb = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (a_en) a_vld_q <= in_valid_i;
      if (b_en) b_vld_q <= a_vld_q;
      if (c_en) c_vld_q <= b_vld_q;
      if (d_en) d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_err_q  <= {1'b0, led_i} >= 9'(LedCount);
      a_base_q <= SlotW'({led_i, 4'b0}) + SlotW'({led_i, 3'b0});
      a_sec_q  <= a_sec_d;
      a_off_q  <= a_off_d;
      a_v_q    <= val_i;
      a_p_q    <= 16'(sat_i) * 16'(val_i);
    end
    if (b_en) begin
      b_err_q    <= a_err_q;
      b_base_q   <= a_base_q;
      b_sec_q    <= a_sec_q;
      b_off_q    <= a_off_q;
      b_v_q      <= a_v_q;
      b_chroma_q <= b_t[15:8];
      b_lo_q     <= a_v_q - b_t[15:8];
    end
    if (c_en) begin
      c_err_q  <= b_err_q;
      c_base_q <= b_base_q;
      c_sec_q  <= b_sec_q;
      c_v_q    <= b_v_q;
      c_lo_q   <= b_lo_q;
      c_m_q    <= 14'(b_chroma_q) * 14'(b_off_q);
    end
    if (d_en) begin
      d_item_q <= d_item_d;
    end
  end

  assign out_valid_o = d_vld_q;
  assign out_item_o  = d_item_q;

endmodule

`default_nettype wire

// File: rtl/hsvws_serializer.sv
// Serializer: shifts the GRB word out MSB first as 24 duty codes with slots.
// Depends on hsvws_pkg.
`default_nettype none

module hsvws_serializer
  import hsvws_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire duty_cfg_t cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pix_item_t in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [SlotW-1:0] slot_o,
  output logic [DutyW-1:0] code_o,
  output logic           err_o,
  output logic           last_o
);

  logic             vld_q;
  logic             err_q;
  logic [SlotW-1:0] base_q;
  logic [23:0]      grb_q;
  logic [CntW-1:0]  cnt_q;
  logic             take, done, load;

  assign last_o     = err_q | (cnt_q == CntW'(BitsPerLed - 1));
  assign take       = vld_q & out_ready_i;
  assign done       = take & last_o;
  assign in_ready_o = ~vld_q | done;
  assign load       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else if (load) begin
      vld_q <= 1'b1;
      cnt_q <= '0;
    end else if (done) begin
      vld_q <= 1'b0;
    end else if (take) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q  <= in_item_i.err;
      base_q <= in_item_i.base;
      grb_q  <= in_item_i.grb;
    end else if (take) begin
      grb_q <= {grb_q[22:0], 1'b0};
    end
  end

  assign out_valid_o = vld_q;
  assign err_o       = err_q;
  assign slot_o      = err_q ? '0 : base_q + SlotW'(cnt_q);
  always_comb begin
    if (err_q) begin
      code_o = '0;
    end else if (grb_q[23]) begin
      code_o = cfg_i.duty_one;
    end else begin
      code_o = cfg_i.duty_zero;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsv_to_ws2812_pulse_encoder_unit.sv
// HSV to WS2812 pulse encoder: top level.
// Uses hsvws_pkg, hsvws_cfg_regs, hsvws_color_pipe and hsvws_serializer.
//
// Slave stream takes one request per LED: index, hue (degrees), saturation
// and value. Master stream returns 24 duty codes per LED, G MSB first, each
// with its pulse buffer slot led*24+bit; tlast marks the 24th. An index at
// or beyond the strip length gives one result with tuser set, tlast set and
// zero data. APB port: duty code for a one bit at 0x0, for a zero at 0x4.
//
// The first code of a request passes the four colour stages and then the
// serializer register. One code per cycle while the master side is ready;
// a colour request occupies the serializer for its 24 codes, an error
// request for one code. The colour pipeline buffers up to
// four more requests and keeps taking them while the serializer works.
// Reset clears all valid bits and loads the duty codes 40 and 20.
// A stalled master side holds the current code and fills the pipeline;
// tready on the slave side drops once all stages are full.
`default_nettype none

module hsv_to_ws2812_pulse_encoder_unit
  import hsvws_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [7:0] led_index, [16:8] hue, [24:17] saturation, [32:25] brightness
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [13:0] slot_address, [19:14] pulse_code
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // [0] index_error
  output logic                     m_axis_tuser_o,
  output logic                     m_axis_tlast_o,
  input  wire logic                psel_i,
  input  wire logic                penable_i,
  input  wire logic                pwrite_i,
  input  wire logic [ApbAddrW-1:0] paddr_i,
  input  wire logic [31:0]         pwdata_i,
  output logic      [31:0]         prdata_o,
  output logic                     pready_o
);

  duty_cfg_t        cfg;
  logic             pix_valid, pix_ready;
  pix_item_t        pix_item;
  logic [SlotW-1:0] slot;
  logic [DutyW-1:0] code;

  hsvws_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  hsvws_color_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .led_i       (s_axis_tdata_i[7:0]),
    .hue_i       (s_axis_tdata_i[16:8]),
    .sat_i       (s_axis_tdata_i[24:17]),
    .val_i       (s_axis_tdata_i[32:25]),
    .out_valid_o (pix_valid),
    .out_ready_i (pix_ready),
    .out_item_o  (pix_item)
  );

  hsvws_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (pix_valid),
    .in_ready_o  (pix_ready),
    .in_item_i   (pix_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .slot_o      (slot),
    .code_o      (code),
    .err_o       (m_axis_tuser_o),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OutDataW-SlotW-DutyW){1'b0}}, code, slot};

endmodule

`default_nettype wire
